### src/chm_pkg.sv
package chm_pkg;

	localparam int ENTRIES_DEF = 256;
	localparam int BUCKETS_DEF = 257;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int OP_W = 2;
	localparam int ST_W = 2;
	localparam int CFG_W = 9;

	localparam logic [KEY_W-1:0] HASH_MUL = 32'd2654435761;
	localparam logic [CFG_W-1:0] CFG_RESET = 9'd257;

	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [VAL_W-1:0] found_value;
	} rsp_t;

endpackage

### src/chm_fifo.sv
module chm_fifo #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] wdata,
	output logic full,
	input logic pop,
	output logic nonempty,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem_q [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wptr_q <= ~wptr_q;
			end
			if (pop && nonempty) begin
				rptr_q <= ~rptr_q;
			end
			if ((push && !full) && !(pop && nonempty)) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!(push && !full) && (pop && nonempty)) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### src/chm_front.sv
module chm_front #(
	parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
	parameter int BW = $clog2(BUCKETS)
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input chm_pkg::req_t req,
	input logic cfg_valid,
	input logic [chm_pkg::CFG_W-1:0] cfg_data,
	output logic push,
	output logic [chm_pkg::OP_W+chm_pkg::KEY_W+chm_pkg::VAL_W+BW-1:0] job,
	input logic full
);

	localparam int NW = ($clog2(BUCKETS + 1) > chm_pkg::CFG_W) ?
		$clog2(BUCKETS + 1) : chm_pkg::CFG_W;
	localparam int CW = $clog2(chm_pkg::KEY_W);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

	fstate_t state_q;
	logic [chm_pkg::CFG_W-1:0] cfg_q;
	chm_pkg::req_t req_q;
	logic [chm_pkg::KEY_W-1:0] hash_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] n_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] cfg_ext;
	logic [NW-1:0] n_sel;
	logic [NW:0] trial;
	logic [NW:0] diff;

	assign req_ready = (state_q == F_IDLE);
	assign push = (state_q == F_PUSH);
	assign job = {req_q.op, req_q.key, req_q.value, rem_q[BW-1:0]};

	assign cfg_ext = NW'(cfg_q);
	always_comb begin
		if (cfg_ext == '0) begin
			n_sel = NW'(1);
		end else if (cfg_ext > NW'(BUCKETS)) begin
			n_sel = NW'(BUCKETS);
		end else begin
			n_sel = cfg_ext;
		end
	end

	assign trial = {rem_q, hash_q[chm_pkg::KEY_W-1]};
	assign diff = trial - {1'b0, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cfg_q <= chm_pkg::CFG_RESET;
			req_q <= '0;
			hash_q <= '0;
			rem_q <= '0;
			n_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			case (state_q)
				F_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						hash_q <= req.key * chm_pkg::HASH_MUL;
						rem_q <= '0;
						n_q <= n_sel;
						cnt_q <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					if (trial >= {1'b0, n_q}) begin
						rem_q <= diff[NW-1:0];
					end else begin
						rem_q <= trial[NW-1:0];
					end
					hash_q <= {hash_q[chm_pkg::KEY_W-2:0], 1'b0};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(chm_pkg::KEY_W - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

### src/chm_back.sv
module chm_back #(
	parameter int ENTRIES = chm_pkg::ENTRIES_DEF,
	parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
	parameter int BW = $clog2(BUCKETS)
) (
	input logic clk,
	input logic arst_n,
	input logic nonempty,
	input logic [chm_pkg::OP_W+chm_pkg::KEY_W+chm_pkg::VAL_W+BW-1:0] job,
	output logic pop,
	output logic rsp_valid,
	input logic rsp_ready,
	output chm_pkg::rsp_t rsp
);

	localparam int EW = $clog2(ENTRIES);
	localparam int IW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] NIL = IW'(ENTRIES);

	typedef enum logic [2:0] {
		B_CLEAR, B_IDLE, B_HEAD, B_CHK, B_WALK, B_CMP, B_FIX, B_DONE
	} bstate_t;

	bstate_t state_q;
	logic [chm_pkg::OP_W-1:0] op_q;
	logic [chm_pkg::KEY_W-1:0] key_q;
	logic [chm_pkg::VAL_W-1:0] val_q;
	logic [BW-1:0] bkt_q;
	logic [BW-1:0] clr_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] prev_q;
	logic [IW-1:0] steps_q;
	logic [IW-1:0] free_q;
	logic [IW-1:0] fill_q;
	logic [chm_pkg::ST_W-1:0] st_q;
	logic [chm_pkg::VAL_W-1:0] fv_q;
	logic rsp_valid_q;
	chm_pkg::rsp_t rsp_q;

	logic [IW-1:0] heads_mem [BUCKETS];
	logic [IW-1:0] next_mem [ENTRIES];
	logic [chm_pkg::KEY_W-1:0] keys_mem [ENTRIES];
	logic [chm_pkg::VAL_W-1:0] vals_mem [ENTRIES];

	logic [IW-1:0] head_rd;
	logic [IW-1:0] next_rd;
	logic [chm_pkg::KEY_W-1:0] key_rd;
	logic [chm_pkg::VAL_W-1:0] val_rd;

	logic head_we;
	logic [BW-1:0] head_wa;
	logic [IW-1:0] head_wd;
	logic next_we;
	logic [EW-1:0] next_wa;
	logic [IW-1:0] next_wd;
	logic [EW-1:0] next_ra;
	logic kv_we;
	logic hit;

	assign pop = (state_q == B_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign hit = (key_rd == key_q);

	always_comb begin
		head_we = 1'b0;
		head_wa = bkt_q;
		head_wd = free_q;
		next_we = 1'b0;
		next_wa = free_q[EW-1:0];
		next_wd = head_rd;
		next_ra = free_q[EW-1:0];
		kv_we = 1'b0;
		case (state_q)
			B_CLEAR: begin
				head_we = 1'b1;
				head_wa = clr_q;
				head_wd = NIL;
			end
			B_CHK: begin
				if (op_q == chm_pkg::OP_ADD && free_q != NIL) begin
					head_we = 1'b1;
					next_we = 1'b1;
					kv_we = 1'b1;
				end
			end
			B_WALK: begin
				next_ra = cur_q[EW-1:0];
			end
			B_CMP: begin
				if (hit && op_q == chm_pkg::OP_REMOVE) begin
					if (prev_q == NIL) begin
						head_we = 1'b1;
						head_wd = next_rd;
					end else begin
						next_we = 1'b1;
						next_wa = prev_q[EW-1:0];
						next_wd = next_rd;
					end
				end
			end
			B_FIX: begin
				next_we = 1'b1;
				next_wa = cur_q[EW-1:0];
				next_wd = free_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			heads_mem[head_wa] <= head_wd;
		end
		head_rd <= heads_mem[bkt_q];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd <= next_mem[next_ra];
	end

	always_ff @(posedge clk) begin
		if (kv_we) begin
			keys_mem[free_q[EW-1:0]] <= key_q;
			vals_mem[free_q[EW-1:0]] <= val_q;
		end
		key_rd <= keys_mem[cur_q[EW-1:0]];
		val_rd <= vals_mem[cur_q[EW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			op_q <= '0;
			key_q <= '0;
			val_q <= '0;
			bkt_q <= '0;
			clr_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			steps_q <= '0;
			free_q <= '0;
			fill_q <= '0;
			st_q <= chm_pkg::ST_MISS;
			fv_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != B_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (nonempty) begin
						{op_q, key_q, val_q, bkt_q} <= job;
						st_q <= chm_pkg::ST_MISS;
						fv_q <= '0;
						state_q <= B_HEAD;
					end
				end
				B_HEAD: begin
					state_q <= B_CHK;
				end
				B_CHK: begin
					if (op_q == chm_pkg::OP_ADD) begin
						if (free_q == NIL) begin
							st_q <= chm_pkg::ST_FULL;
						end else begin
							st_q <= chm_pkg::ST_OK;
							if (free_q == fill_q) begin
								free_q <= free_q + IW'(1);
								fill_q <= fill_q + IW'(1);
							end else begin
								free_q <= next_rd;
							end
						end
						state_q <= B_DONE;
					end else if (op_q == chm_pkg::OP_LOOKUP || op_q == chm_pkg::OP_REMOVE) begin
						cur_q <= head_rd;
						prev_q <= NIL;
						steps_q <= '0;
						state_q <= B_WALK;
					end else begin
						state_q <= B_DONE;
					end
				end
				B_WALK: begin
					if (cur_q == NIL || steps_q == NIL) begin
						state_q <= B_DONE;
					end else begin
						state_q <= B_CMP;
					end
				end
				B_CMP: begin
					if (hit) begin
						st_q <= chm_pkg::ST_OK;
						fv_q <= val_rd;
						if (op_q == chm_pkg::OP_REMOVE) begin
							state_q <= B_FIX;
						end else begin
							state_q <= B_DONE;
						end
					end else begin
						prev_q <= cur_q;
						cur_q <= next_rd;
						steps_q <= steps_q + IW'(1);
						state_q <= B_WALK;
					end
				end
				B_FIX: begin
					free_q <= cur_q;
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q.status <= st_q;
						rsp_q.found_value <= fv_q;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NIL)
		else $error("fill count beyond pool size");

	a_free_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q <= fill_q) || (free_q == NIL))
		else $error("free list head points past the filled region");

	a_walk_written: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CMP) |-> (cur_q < fill_q))
		else $error("chain walk reached an entry never written");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != chm_pkg::ST_OK) |-> (rsp_q.found_value == '0))
		else $error("nonzero value on a miss or full response");

endmodule

### src/chained_hash_map.sv
// Hash map from 32-bit keys to 32-bit values with separate chaining.
// Requests enter on req (valid/ready): op 0 adds a key and value, op 1 looks
// a key up, op 2 looks it up and removes the first match. Each request gives
// exactly one response on rsp (valid/ready) with a status and found value.
// The bucket count must be written by the user on the cfg channel only while
// the map is idle; the block itself does not enforce this. A front end hashes
// the key with one multiply and a 32-step remainder unit, then hands the
// request through a two-entry queue to the table back end. The front end takes
// one request at a time: it accepts, runs the 32 remainder steps, and pushes
// into the queue once the queue has room, after which it accepts again. The
// back end reads the bucket head; an add links a new entry at the chain head,
// a lookup or remove walks the chain one link at a time, and a remove unlinks
// the match and returns it to the free list. After reset the bucket head memory
// is cleared, one bucket per cycle, for all BUCKETS buckets; requests queue
// up but are not served until it completes. A held response stalls the back
// end only; the front end and queue accept requests until the queue is full.
module chained_hash_map #(
	parameter int ENTRIES = chm_pkg::ENTRIES_DEF,
	parameter int BUCKETS = chm_pkg::BUCKETS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input chm_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output chm_pkg::rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [chm_pkg::CFG_W-1:0] cfg_data
);

	localparam int BW = $clog2(BUCKETS);
	localparam int JW = chm_pkg::OP_W + chm_pkg::KEY_W + chm_pkg::VAL_W + BW;

	logic push;
	logic full;
	logic pop;
	logic nonempty;
	logic [JW-1:0] job_in;
	logic [JW-1:0] job_out;

	assign cfg_ready = 1'b1;

	chm_front #(
		.BUCKETS(BUCKETS),
		.BW(BW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.push(push),
		.job(job_in),
		.full(full)
	);

	chm_fifo #(
		.W(JW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(job_in),
		.full(full),
		.pop(pop),
		.nonempty(nonempty),
		.rdata(job_out)
	);

	chm_back #(
		.ENTRIES(ENTRIES),
		.BUCKETS(BUCKETS),
		.BW(BW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.nonempty(nonempty),
		.job(job_out),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule

### sim/chained_hash_map_tb.sv
module chained_hash_map_tb;

	localparam int N_ENT = 256;
	localparam int N_BKT = 257;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [chm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	chm_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	chm_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [chm_pkg::CFG_W-1:0] cfg_data = '0;

	chained_hash_map i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the table state.
	logic [chm_pkg::CFG_W-1:0] map_buckets;
	logic [8:0] map_heads[N_BKT];
	logic [8:0] map_next[N_ENT];
	logic [31:0] map_keys[N_ENT];
	logic [31:0] map_vals[N_ENT];
	logic [8:0] map_free;
	chm_pkg::rsp_t pending_rsp[$];
	logic [31:0] live_keys[$];
	int error_count = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit allow_idle = 1'b1;
	bit tb_done = 1'b0;

	function automatic int bucket_index(logic [31:0] key);
		logic [31:0] h;
		int n;
		h = key * chm_pkg::HASH_MUL;
		n = int'(map_buckets);
		if (n == 0) n = 1;
		if (n > N_BKT) n = N_BKT;
		return int'(h % 32'(n));
	endfunction

	function automatic chm_pkg::rsp_t map_apply(chm_pkg::req_t r);
		chm_pkg::rsp_t o;
		int b;
		int e;
		int prev;
		int steps;
		o.status = chm_pkg::ST_MISS;
		o.found_value = '0;
		if (r.op == chm_pkg::OP_ADD) begin
			if (map_free >= N_ENT) begin
				o.status = chm_pkg::ST_FULL;
			end else begin
				e = int'(map_free);
				map_free = map_next[e];
				b = bucket_index(r.key);
				map_next[e] = map_heads[b];
				map_keys[e] = r.key;
				map_vals[e] = r.value;
				map_heads[b] = 9'(e);
				o.status = chm_pkg::ST_OK;
			end
		end else if (r.op == chm_pkg::OP_LOOKUP || r.op == chm_pkg::OP_REMOVE) begin
			b = bucket_index(r.key);
			prev = N_ENT;
			e = int'(map_heads[b]);
			steps = 0;
			while (e < N_ENT && steps < N_ENT) begin
				if (map_keys[e] == r.key) begin
					o.status = chm_pkg::ST_OK;
					o.found_value = map_vals[e];
					if (r.op == chm_pkg::OP_REMOVE) begin
						if (prev >= N_ENT) map_heads[b] = map_next[e];
						else map_next[prev] = map_next[e];
						map_next[e] = map_free;
						map_free = 9'(e);
					end
					break;
				end
				prev = e;
				e = int'(map_next[e]);
				steps++;
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic random_gap();
		if (allow_idle && $urandom_range(3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	task automatic send_request(logic [1:0] op, logic [31:0] key, logic [31:0] value);
		chm_pkg::req_t r;
		r.op = op;
		r.key = key;
		r.value = value;
		random_gap();
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(map_apply(r));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_buckets(logic [chm_pkg::CFG_W-1:0] n);
		wait_idle();
		cfg_data <= n;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		map_buckets = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_key();
		if (live_keys.size() != 0 && $urandom_range(3) != 0)
			return live_keys[$urandom_range(live_keys.size() - 1)];
		return $urandom();
	endfunction

	// Random traffic; a small key set makes hits, collisions and duplicates common.
	task automatic run_random(int count, int add_weight);
		logic [31:0] k;
		int sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			k = pick_key();
			if (sel < add_weight) begin
				send_request(chm_pkg::OP_ADD, k, $urandom());
				live_keys.push_back(k);
				if (live_keys.size() > 40) live_keys.delete(0);
			end else if (sel < 96) begin
				send_request(sel[0] ? chm_pkg::OP_REMOVE : chm_pkg::OP_LOOKUP, k, $urandom());
			end else begin
				send_request(OP_UNUSED, k, $urandom());
			end
		end
	endtask

	task automatic test_directed();
		send_request(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
		send_request(chm_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF);
		send_request(chm_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0);
		send_request(chm_pkg::OP_ADD, 32'h0, 32'h1234_5678);
		send_request(chm_pkg::OP_LOOKUP, 32'h0, 32'hFFFF_FFFF);
		send_request(chm_pkg::OP_REMOVE, 32'h0, 32'h0);
		send_request(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
		send_request(chm_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(chm_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(OP_UNUSED, 32'h0, 32'hFFFF_FFFF);
		send_request(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
	endtask

	task automatic test_small_buckets();
		write_buckets(9'd0);
		for (int i = 0; i < 6; i++) send_request(chm_pkg::OP_ADD, 32'(i), ~32'(i));
		send_request(chm_pkg::OP_REMOVE, 32'd2, 32'd0);
		send_request(chm_pkg::OP_LOOKUP, 32'd0, 32'd0);
		write_buckets(9'd1);
		run_random(150, 45);
		write_buckets(9'd3);
		send_request(chm_pkg::OP_LOOKUP, 32'd4, 32'd0);
		run_random(150, 45);
	endtask

	task automatic test_full_pool();
		write_buckets(9'd511);
		for (int i = 0; i < N_ENT + 4; i++)
			send_request(chm_pkg::OP_ADD, $urandom(), $urandom());
		send_request(chm_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'd0);
		run_random(200, 50);
	endtask

	task automatic test_random();
		write_buckets(9'd258);
		run_random(150, 40);
		write_buckets(9'd17);
		run_random(100, 40);
		write_buckets(9'd257);
		allow_idle = 1'b0;
		run_random(100, 40);
	endtask

	always @(posedge clk) begin
		chm_pkg::rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response", rsp.found_value, 32'd0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.found_value !== want.found_value)
					report_mismatch("found_value", rsp.found_value, want.found_value);
			end
		end
	end

	always @(negedge clk) begin
		if (!allow_idle) begin
			stall_left = 0;
			rsp_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if ($urandom_range(3) == 0) begin
			stall_left = $urandom_range(0, 4);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)
				|| !arst_n || tb_done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout");
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		map_buckets = chm_pkg::CFG_RESET;
		for (int i = 0; i < N_BKT; i++) map_heads[i] = 9'(N_ENT);
		for (int i = 0; i < N_ENT; i++) begin
			map_next[i] = 9'(i + 1);
			map_keys[i] = '0;
			map_vals[i] = '0;
		end
		map_free = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_small_buckets();
		test_full_pool();
		test_random();
		wait_idle();
		tb_done = 1'b1;
		if (error_count == 0 && pending_rsp.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
